FILE: rtl/scpf_pkg.sv
// Package for the servo command packet framer.
// Holds the framing constants, byte slot codes and the job record passed from
// the front to the back. No dependencies.
`timescale 1ns / 1ps

package scpf_pkg;

   localparam int MAX_PARAMS_DEFAULT = 12;
   localparam int QUEUE_DEPTH        = 2;

   localparam logic [7:0] SYNC_BYTE = 8'hFF;
   localparam logic [7:0] TERM_BYTE = 8'h0A;
   localparam logic [7:0] LEN_EXTRA = 8'd3;

   localparam logic [3:0] SLOT_SYNC0    = 4'd0;
   localparam logic [3:0] SLOT_SYNC1    = 4'd1;
   localparam logic [3:0] SLOT_ID       = 4'd2;
   localparam logic [3:0] SLOT_LENGTH   = 4'd3;
   localparam logic [3:0] SLOT_INSTR    = 4'd4;
   localparam logic [3:0] SLOT_ADDRESS  = 4'd5;
   localparam logic [3:0] SLOT_PARAM    = 4'd6;
   localparam logic [3:0] SLOT_CHECKSUM = 4'd7;
   localparam logic [3:0] SLOT_TERM     = 4'd8;

   typedef struct packed {
      logic       has_header;
      logic       has_param;
      logic       has_close;
      logic [7:0] servo_id;
      logic [7:0] length;
      logic [7:0] instruction;
      logic [7:0] reg_address;
      logic [7:0] param_byte;
      logic [7:0] checksum;
   } job_type;

endpackage

FILE: rtl/scpf_front.sv
// Front end of the servo command packet framer.
// Accepts request transactions, tracks packet state and checksum, and builds
// one job per transaction. Depends on scpf_pkg.
`timescale 1ns / 1ps

module scpf_front #(
   parameter int MAX_PARAMS = scpf_pkg::MAX_PARAMS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [7:0]        servo_id,
   input  logic [7:0]        instruction,
   input  logic [7:0]        reg_address,
   input  logic [3:0]        param_count,
   input  logic [7:0]        param_byte,
   output scpf_pkg::job_type job
);

   localparam logic [7:0] MaxParamsW = 8'(MAX_PARAMS);

   logic       in_packet_ff, in_packet_in;
   logic [3:0] params_left_ff, params_left_in;
   logic [7:0] running_sum_ff, running_sum_in;

   logic [3:0] count_sat;
   logic [7:0] length;
   logic [7:0] head_sum;
   logic [7:0] base_sum;
   logic [7:0] new_sum;
   logic [3:0] left;
   logic [3:0] left_next;
   logic       has_param;
   logic       close;

   always_comb begin
      count_sat = ({4'b0, param_count} > MaxParamsW) ? MaxParamsW[3:0] : param_count;
      length    = {4'b0, count_sat} + scpf_pkg::LEN_EXTRA;
      head_sum  = servo_id + length + instruction + reg_address;
      base_sum  = in_packet_ff ? running_sum_ff : head_sum;
      left      = in_packet_ff ? params_left_ff : count_sat;
      has_param = in_packet_ff || (count_sat != 4'd0);
      new_sum   = has_param ? base_sum + param_byte : base_sum;
      left_next = (left != 4'd0) ? left - 4'd1 : 4'd0;
      close     = (left_next == 4'd0);

      job.has_header  = !in_packet_ff;
      job.has_param   = has_param;
      job.has_close   = close;
      job.servo_id    = servo_id;
      job.length      = length;
      job.instruction = instruction;
      job.reg_address = reg_address;
      job.param_byte  = param_byte;
      job.checksum    = ~new_sum;
   end

   always_comb begin
      in_packet_in   = in_packet_ff;
      params_left_in = params_left_ff;
      running_sum_in = running_sum_ff;
      if (push) begin
         in_packet_in   = !close;
         params_left_in = close ? 4'd0 : left_next;
         running_sum_in = close ? 8'd0 : new_sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_packet_ff   <= 1'b0;
         params_left_ff <= 4'd0;
         running_sum_ff <= 8'd0;
      end else begin
         in_packet_ff   <= in_packet_in;
         params_left_ff <= params_left_in;
         running_sum_ff <= running_sum_in;
      end
   end

endmodule

FILE: rtl/scpf_queue.sv
// Job queue between front and back of the servo command packet framer.
// Small register FIFO of job records. Depends on scpf_pkg.
`timescale 1ns / 1ps

module scpf_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  scpf_pkg::job_type push_job,
   output logic              full,
   input  logic              pop,
   output logic              not_empty,
   output scpf_pkg::job_type head_job
);

   localparam int PtrW = (scpf_pkg::QUEUE_DEPTH > 1) ? $clog2(scpf_pkg::QUEUE_DEPTH) : 1;
   localparam int CntW = $clog2(scpf_pkg::QUEUE_DEPTH + 1);
   localparam logic [CntW-1:0] DepthC = CntW'(scpf_pkg::QUEUE_DEPTH);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(scpf_pkg::QUEUE_DEPTH - 1);

   scpf_pkg::job_type entry_ff [scpf_pkg::QUEUE_DEPTH];

   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   assign full      = (count_ff == DepthC);
   assign not_empty = (count_ff != '0);
   assign head_job  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: rtl/scpf_back.sv
// Back end of the servo command packet framer.
// Steps through the byte slots of one job at a time and drives the registered
// response stage. Depends on scpf_pkg.
`timescale 1ns / 1ps

module scpf_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   input  scpf_pkg::job_type job_in,
   output logic              job_pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [7:0]        rsp_tx_byte,
   output logic              rsp_end_of_run,
   output logic              rsp_end_of_packet
);

   logic              busy_ff, busy_in;
   logic [3:0]        slot_ff, slot_in;
   scpf_pkg::job_type job_ff, job_in_sel;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        tx_byte_ff, tx_byte_in;
   logic              end_of_run_ff, end_of_run_in;
   logic              end_of_packet_ff, end_of_packet_in;

   logic              out_free;
   logic              advance;
   logic              is_last;
   logic [7:0]        slot_byte;
   logic [3:0]        next_slot;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign advance  = busy_ff && out_free;
   assign is_last  = job_ff.has_close ? (slot_ff == scpf_pkg::SLOT_TERM)
                                      : (slot_ff == scpf_pkg::SLOT_PARAM);
   assign job_pop  = job_valid && (!busy_ff || (advance && is_last));

   always_comb begin
      case (slot_ff)
         scpf_pkg::SLOT_SYNC0:    slot_byte = scpf_pkg::SYNC_BYTE;
         scpf_pkg::SLOT_SYNC1:    slot_byte = scpf_pkg::SYNC_BYTE;
         scpf_pkg::SLOT_ID:       slot_byte = job_ff.servo_id;
         scpf_pkg::SLOT_LENGTH:   slot_byte = job_ff.length;
         scpf_pkg::SLOT_INSTR:    slot_byte = job_ff.instruction;
         scpf_pkg::SLOT_ADDRESS:  slot_byte = job_ff.reg_address;
         scpf_pkg::SLOT_PARAM:    slot_byte = job_ff.param_byte;
         scpf_pkg::SLOT_CHECKSUM: slot_byte = job_ff.checksum;
         scpf_pkg::SLOT_TERM:     slot_byte = scpf_pkg::TERM_BYTE;
         default:                 slot_byte = scpf_pkg::TERM_BYTE;
      endcase
   end

   always_comb begin
      if (slot_ff == scpf_pkg::SLOT_ADDRESS) begin
         next_slot = job_ff.has_param ? scpf_pkg::SLOT_PARAM : scpf_pkg::SLOT_CHECKSUM;
      end else begin
         next_slot = slot_ff + 4'd1;
      end
   end

   always_comb begin
      busy_in    = busy_ff;
      slot_in    = slot_ff;
      job_in_sel = job_ff;
      if (advance) begin
         slot_in = next_slot;
         if (is_last) begin
            busy_in = 1'b0;
         end
      end
      if (job_pop) begin
         busy_in    = 1'b1;
         job_in_sel = job_in;
         slot_in    = job_in.has_header ? scpf_pkg::SLOT_SYNC0 : scpf_pkg::SLOT_PARAM;
      end
   end

   always_comb begin
      rsp_valid_in     = rsp_valid_ff;
      tx_byte_in       = tx_byte_ff;
      end_of_run_in    = end_of_run_ff;
      end_of_packet_in = end_of_packet_ff;
      if (out_free) begin
         rsp_valid_in     = busy_ff;
         tx_byte_in       = slot_byte;
         end_of_run_in    = is_last;
         end_of_packet_in = (slot_ff == scpf_pkg::SLOT_TERM);
      end
   end

   always_ff @(posedge clock) begin
      job_ff           <= job_in_sel;
      tx_byte_ff       <= tx_byte_in;
      end_of_run_ff    <= end_of_run_in;
      end_of_packet_ff <= end_of_packet_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         slot_ff      <= scpf_pkg::SLOT_SYNC0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         slot_ff      <= slot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_tx_byte       = tx_byte_ff;
   assign rsp_end_of_run    = end_of_run_ff;
   assign rsp_end_of_packet = end_of_packet_ff;

`ifndef NO_ASSERTIONS
   a_eop_ends_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && end_of_packet_ff |-> end_of_run_ff)
      else $error("terminator byte without end of run");

   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> slot_ff <= scpf_pkg::SLOT_TERM)
      else $error("byte slot out of range");

   a_pop_on_last: assert property (@(posedge clock) disable iff (reset)
      job_pop && busy_ff |-> advance && is_last)
      else $error("job taken while previous job unfinished");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> rsp_valid_ff && $stable(tx_byte_ff))
      else $error("response changed under stall");
`endif

endmodule

FILE: rtl/servo_command_packet_framer.sv
// Servo command packet framer: turns request transactions into the byte
// stream of servo instruction packets, one response transaction per byte.
// The single registered output stage sends one byte per cycle unless
// rsp_stall holds it. A request causes 7 to 9 bytes for the
// first request of a packet, 1 for a later parameter, 3 for the one that
// closes the packet. A two-entry job queue lets requests be taken while the
// output is still busy or stalled. Depends on scpf_pkg, scpf_front,
// scpf_queue and scpf_back.
`timescale 1ns / 1ps

module servo_command_packet_framer #(
   parameter int MAX_PARAMS = scpf_pkg::MAX_PARAMS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_servo_id,
   input  logic [7:0] req_instruction,
   input  logic [7:0] req_reg_address,
   input  logic [3:0] req_param_count,
   input  logic [7:0] req_param_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_tx_byte,
   output logic       rsp_end_of_run,
   output logic       rsp_end_of_packet
);

   scpf_pkg::job_type new_job;
   scpf_pkg::job_type head_job;
   logic              push;
   logic              full;
   logic              pop;
   logic              not_empty;

   assign req_stall = full;
   assign push      = req_valid && !full;

   scpf_front #(
      .MAX_PARAMS(MAX_PARAMS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .servo_id    (req_servo_id),
      .instruction (req_instruction),
      .reg_address (req_reg_address),
      .param_count (req_param_count),
      .param_byte  (req_param_byte),
      .job         (new_job)
   );

   scpf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (new_job),
      .full      (full),
      .pop       (pop),
      .not_empty (not_empty),
      .head_job  (head_job)
   );

   scpf_back u_back (
      .clock             (clock),
      .reset             (reset),
      .job_valid         (not_empty),
      .job_in            (head_job),
      .job_pop           (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_tx_byte       (rsp_tx_byte),
      .rsp_end_of_run    (rsp_end_of_run),
      .rsp_end_of_packet (rsp_end_of_packet)
   );

endmodule

FILE: dv/servo_command_packet_framer_tb.sv
// Testbench for servo_command_packet_framer: drives request transactions and
// checks every framed byte against an in-bench packet builder.
// Depends on scpf_pkg and the framer RTL.
`timescale 1ns / 1ps

module servo_command_packet_framer_tb;

   localparam int MAX_PARAMS = scpf_pkg::MAX_PARAMS_DEFAULT;
   localparam logic [3:0] MAX_COUNT = 4'(MAX_PARAMS);
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int TAIL_CYCLES = 30;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       end_of_run;
      logic       end_of_packet;
   } frame_byte_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_servo_id = 8'd0;
   logic [7:0] req_instruction = 8'd0;
   logic [7:0] req_reg_address = 8'd0;
   logic [3:0] req_param_count = 4'd0;
   logic [7:0] req_param_byte = 8'd0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_tx_byte;
   logic       rsp_end_of_run;
   logic       rsp_end_of_packet;

   frame_byte_type framed_bytes_due[$];
   logic        pkt_open = 1'b0;
   logic [3:0]  pkt_left = 4'd0;
   logic [7:0]  pkt_sum = 8'd0;
   int          mismatch_count = 0;
   int          quiet_cycles = 0;
   int          send_idle_pct = 0;
   int          stall_pct = 0;

   servo_command_packet_framer #(.MAX_PARAMS(MAX_PARAMS)) u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_servo_id      (req_servo_id),
      .req_instruction   (req_instruction),
      .req_reg_address   (req_reg_address),
      .req_param_count   (req_param_count),
      .req_param_byte    (req_param_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_tx_byte       (rsp_tx_byte),
      .rsp_end_of_run    (rsp_end_of_run),
      .rsp_end_of_packet (rsp_end_of_packet)
   );

   always #2 clock = ~clock;

   function automatic frame_byte_type frame_byte(input logic [7:0] value, input logic eop);
      frame_byte_type b;
      b.tx_byte = value;
      b.end_of_run = 1'b0;
      b.end_of_packet = eop;
      return b;
   endfunction

   // Build the bytes one request transaction causes and advance packet state.
   function automatic void frame_request(input logic [7:0] id, input logic [7:0] instr,
                                         input logic [7:0] addr, input logic [3:0] count,
                                         input logic [7:0] param);
      frame_byte_type run[$];
      frame_byte_type last;
      logic [3:0]  n;
      logic [7:0]  len;
      logic        take;
      if (!pkt_open) begin
         n = (count > MAX_COUNT) ? MAX_COUNT : count;
         len = {4'd0, n} + scpf_pkg::LEN_EXTRA;
         run.push_back(frame_byte(scpf_pkg::SYNC_BYTE, 1'b0));
         run.push_back(frame_byte(scpf_pkg::SYNC_BYTE, 1'b0));
         run.push_back(frame_byte(id, 1'b0));
         run.push_back(frame_byte(len, 1'b0));
         run.push_back(frame_byte(instr, 1'b0));
         run.push_back(frame_byte(addr, 1'b0));
         pkt_sum = id + len + instr + addr;
         pkt_left = n;
         take = (n != 4'd0);
      end else begin
         take = 1'b1;
      end
      if (take) begin
         run.push_back(frame_byte(param, 1'b0));
         pkt_sum = pkt_sum + param;
         if (pkt_left != 4'd0)
            pkt_left = pkt_left - 4'd1;
      end
      if (pkt_left == 4'd0) begin
         run.push_back(frame_byte(~pkt_sum, 1'b0));
         run.push_back(frame_byte(scpf_pkg::TERM_BYTE, 1'b1));
         pkt_open = 1'b0;
         pkt_sum = 8'd0;
      end else begin
         pkt_open = 1'b1;
      end
      last = run[run.size() - 1];
      last.end_of_run = 1'b1;
      run[run.size() - 1] = last;
      foreach (run[i])
         framed_bytes_due.push_back(run[i]);
   endfunction

   function automatic logic [7:0] pick_byte();
      int sel;
      sel = $urandom_range(7);
      if (sel == 0)
         return 8'h00;
      if (sel == 1)
         return 8'hFF;
      return 8'($urandom);
   endfunction

   // Hold valid low for random idle cycles, then present one transaction
   // until it is taken.
   task automatic send_request(input logic [7:0] id, input logic [7:0] instr,
                               input logic [7:0] addr, input logic [3:0] count,
                               input logic [7:0] param);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_servo_id    <= id;
      req_instruction <= instr;
      req_reg_address <= addr;
      req_param_count <= count;
      req_param_byte  <= param;
      frame_request(id, instr, addr, count, param);
      do
         @(posedge clock);
      while (req_stall);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (framed_bytes_due.size() != 0)
         @(posedge clock);
   endtask

   // Later items carry random header fields, which must be ignored.
   task automatic send_packet(input logic [3:0] count, input bit pause_each);
      int items;
      items = (count == 4'd0) ? 1 : ((count > MAX_COUNT) ? MAX_PARAMS : int'(count));
      for (int i = 0; i < items; i++) begin
         send_request(pick_byte(), pick_byte(), pick_byte(),
                      (i == 0) ? count : 4'($urandom), pick_byte());
         if (pause_each)
            wait_drained();
      end
   endtask

   task automatic test_zero_count();
      send_request(8'h00, 8'h00, 8'h00, 4'd0, 8'hFF);
      send_request(8'hFF, 8'hFF, 8'hFF, 4'd0, 8'h00);
   endtask

   task automatic test_single_param();
      send_request(8'hFE, 8'h03, 8'h1E, 4'd1, 8'hFF);
      send_request(8'h01, 8'hFF, 8'h00, 4'd1, 8'h00);
   endtask

   task automatic test_later_header_ignored();
      send_request(8'h7F, 8'h80, 8'hFF, 4'd2, 8'h00);
      send_request(8'hFF, 8'h00, 8'h00, 4'hF, 8'hFF);
   endtask

   task automatic test_count_saturation();
      send_packet(4'hF, 1'b0);
   endtask

   task automatic test_pause_until_drained();
      send_packet(4'd3, 1'b1);
      send_packet(4'd0, 1'b1);
   endtask

   task automatic test_traffic(input int idle_pct, input int stall_rate, input int n_items);
      int sent;
      int sel;
      logic [3:0] count;
      send_idle_pct = idle_pct;
      stall_pct = stall_rate;
      sent = 0;
      while (sent < n_items) begin
         sel = $urandom_range(9);
         case (sel)
            0: count = 4'd0;
            1: count = 4'd1;
            2: count = MAX_COUNT;
            3: count = 4'($urandom_range(15, MAX_PARAMS + 1));
            default: count = 4'($urandom_range(MAX_PARAMS - 1, 2));
         endcase
         send_packet(count, 1'b0);
         sent += (count == 4'd0) ? 1 : ((count > MAX_COUNT) ? MAX_PARAMS : int'(count));
      end
   endtask

   always @(posedge clock)
      rsp_stall <= ($urandom_range(99) < stall_pct);

   always @(posedge clock) begin
      frame_byte_type got;
      frame_byte_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.tx_byte = rsp_tx_byte;
         got.end_of_run = rsp_end_of_run;
         got.end_of_packet = rsp_end_of_packet;
         if (framed_bytes_due.size() == 0) begin
            $display("%0t: unexpected byte %h eor %b eop %b", $time,
                     got.tx_byte, got.end_of_run, got.end_of_packet);
            mismatch_count++;
         end else begin
            want = framed_bytes_due.pop_front();
            if (got.tx_byte !== want.tx_byte || got.end_of_run !== want.end_of_run ||
                got.end_of_packet !== want.end_of_packet) begin
               $display("%0t: byte exp %h eor %b eop %b, got %h eor %b eop %b", $time,
                        want.tx_byte, want.end_of_run, want.end_of_packet,
                        got.tx_byte, got.end_of_run, got.end_of_packet);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("[servo_command_packet_framer] ERROR");
         $finish;
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_zero_count();
      test_single_param();
      test_later_header_ignored();
      test_count_saturation();
      test_pause_until_drained();
      test_traffic(0, 0, 36);
      test_traffic(60, 0, 36);
      test_traffic(0, 60, 36);
      test_traffic(35, 35, 36);
      req_valid <= 1'b0;
      while (framed_bytes_due.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("[servo_command_packet_framer] OK");
      else
         $display("[servo_command_packet_framer] ERROR");
      $finish;
   end

endmodule
